// File: src/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg: shared types and constants of the position servo core
// Beat formats, command codes, preset positions and fixed-point scaling
// constants used by the servo core and its state stage.
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

  // Fraction bits of the controller gains
  localparam int GainFracBits = 12;

  // Error and correction scale 20/72
  localparam int ScaleNum = 20;
  localparam int ScaleDen = 72;

  // Degrees per encoder turn and encoder resolution
  localparam int DegPerTurn = 360;
  localparam int EncBits    = 12;

  // Error path: |trunc(d*20/72)| = floor(|d|*5/18), reciprocal of 18 in Q16
  localparam int ErrMul     = ScaleNum / 4;
  localparam int ErrDiv     = ScaleDen / 4;
  localparam int ErrRecipSh = 16;
  localparam int ErrRecip   = (1 << ErrRecipSh) / ErrDiv + 1;

  // Correction path widths
  localparam int ProdW   = 28;                // one gain product
  localparam int GsumW   = 29;                // sum of the three products
  localparam int SumW    = 34;                // PID sum times 20
  localparam int ShW     = SumW - GainFracBits; // sum after the Q shift
  localparam int RecipK  = ShW + 1;
  localparam int RecipW  = ShW - 5;
  localparam int QW      = ShW - 6;           // quotient by 72
  localparam int FW      = QW + 1;            // signed duty step
  localparam int SatW    = QW + 2;            // duty before clamping
  localparam logic [RecipW-1:0] Recip72 = RecipW'((64'd1 << RecipK) / ScaleDen);

  // Item commands
  localparam logic [2:0] ModeTick  = 3'd0;
  localparam logic [2:0] ModeUp    = 3'd1;
  localparam logic [2:0] ModeDown  = 3'd2;
  localparam logic [2:0] ModeFrame = 3'd3;
  localparam logic [2:0] ModeStart = 3'd4;

  // Bus frame identifiers
  localparam logic [10:0] FidPresetHigh = 11'h043;
  localparam logic [10:0] FidPresetMid  = 11'h011;
  localparam logic [10:0] FidPresetLow  = 11'h065;
  localparam logic [10:0] FidPosRequest = 11'h050;

  // Reference positions in degrees
  localparam logic [8:0] RefHigh    = 9'd90;
  localparam logic [8:0] RefMid     = 9'd60;
  localparam logic [8:0] RefLow     = 9'd30;
  localparam logic [8:0] UpThresh   = 9'd90;
  localparam logic [8:0] UpTop      = 9'd95;
  localparam logic [8:0] DownThresh = 9'd35;
  localparam logic [8:0] DownBottom = 9'd30;
  localparam logic [8:0] RefStep    = 9'd4;
  localparam logic [8:0] FoldAbove  = 9'd300;
  localparam logic [8:0] PoseLo     = 9'd30;
  localparam logic [8:0] PoseMid    = 9'd50;
  localparam logic [8:0] PoseHi     = 9'd70;

  // Pose codes
  localparam logic [1:0] PoseNear  = 2'd0;
  localparam logic [1:0] PoseCentr = 2'd1;
  localparam logic [1:0] PoseOther = 2'd2;

  // Register map indexes
  localparam logic [2:0] RegGainP       = 3'd0;
  localparam logic [2:0] RegGainI       = 3'd1;
  localparam logic [2:0] RegGainD       = 3'd2;
  localparam logic [2:0] RegDebounce    = 3'd3;
  localparam logic [2:0] RegDutyLimit   = 3'd4;

  // Register reset values
  localparam logic [15:0] GainPReset     = 16'd12922;
  localparam logic [15:0] GainIReset     = 16'd1304;
  localparam logic [15:0] GainDReset     = 16'd6135;
  localparam logic [7:0]  DebounceReset  = 8'd50;
  localparam logic [7:0]  DutyLimitReset = 8'd20;

  // Input beat
  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] raw_angle;
    logic [31:0] press_time_ms;
    logic [10:0] frame_id;
  } item_t;

  // Result beat
  typedef struct packed {
    logic [7:0] drive_a;
    logic [7:0] drive_b;
    logic [8:0] angle_degrees;
    logic [8:0] setpoint;
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic [1:0] pose_index;
  } result_t;

  // Registered input item with the angle already in degrees
  typedef struct packed {
    logic [2:0]  mode;
    logic [8:0]  deg_turn;
    logic [8:0]  deg_fold;
    logic [31:0] press_time_ms;
    logic [10:0] frame_id;
  } entry_t;

  // Status of one item after the state update, carried down the pipe
  typedef struct packed {
    logic       tick;
    logic       e_neg;
    logic [8:0] angle;
    logic [8:0] setpoint;
    logic       reply;
    logic [1:0] pose;
  } snap_t;

endpackage

`default_nettype wire

// File: src/pid_position_servo_with_setpoint_core.sv
// ----------------------------------------------------------------------------
// pid_position_servo_with_setpoint_core: two-direction PWM position servo
// Discrete PID on the encoder angle against a button/bus controlled reference,
// producing clamped duty values for drive channels A and B.
// ----------------------------------------------------------------------------
//  channel | signals                                    | beat
//  --------+--------------------------------------------+----------------------
//  item    | item_valid, item_stall, item               | one command or tick
//  result  | result_valid, result_stall, result         | one per item
//  config  | psel, penable, pwrite, paddr, pwdata, ...  | 32-bit register write
//
// One item per cycle while the result is not stalled; each item passes
// through seven registers (entry, state, products, sum, reciprocal,
// correction, output). State commands resolve in the state stage, duty
// feedback in the output stage, so back-to-back items need no interlock.
// rst is synchronous, clears all valid bits and the servo state, and
// restores the register defaults. A stalled result holds; stages behind it
// keep filling until the pipe is full, then item_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_position_servo_with_setpoint_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire pss_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output pss_pkg::result_t      result,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // Configuration registers
  logic [15:0] gain_p, gain_i_times_period, gain_d_over_period;
  logic [7:0]  debounce_ms, duty_limit;
  logic        cfg_write;

  // Stage valids and readiness
  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy_out;

  // Stage payloads
  pss_pkg::entry_t entry, entry_next;
  logic [20:0]     turn_prod;
  pss_pkg::snap_t  snap_st, snap2, snap3, snap4, snap5, snap6;
  logic signed [7:0] err_st, err2;
  logic signed [9:0] perr_st, perr2;

  logic signed [pss_pkg::ProdW-1:0] gp_w, gi_w, gd_w, e_w, ep_w, dif_w, sum_w;
  logic signed [pss_pkg::ProdW-1:0] prod_p, prod_i, prod_d;
  logic signed [pss_pkg::GsumW-1:0] gsum;
  logic signed [pss_pkg::SumW-1:0]  gsum_x, gsum_s, gsum_20;
  logic signed [pss_pkg::ShW-1:0]   shifted, shifted_next;
  logic [pss_pkg::ShW-1:0]          mag_next, mag5;
  logic                             neg_next, neg5;
  logic [pss_pkg::ShW+pss_pkg::RecipW-1:0] q_prod;
  logic [pss_pkg::QW-1:0]           q_est;
  logic [pss_pkg::ShW:0]            q_x72, rem, rem1;
  logic [pss_pkg::QW-1:0]           q_cor, f_mag;
  logic signed [pss_pkg::FW-1:0]    step_next, step6;
  logic [7:0]                       duty_a, duty_b, prev_duty, duty_new;
  logic signed [pss_pkg::SatW-1:0]  duty_sum;
  pss_pkg::result_t                 result_next;

  // APB port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p              <= pss_pkg::GainPReset;
      gain_i_times_period <= pss_pkg::GainIReset;
      gain_d_over_period  <= pss_pkg::GainDReset;
      debounce_ms         <= pss_pkg::DebounceReset;
      duty_limit          <= pss_pkg::DutyLimitReset;
    end else if (cfg_write) begin
      case (paddr[4:2])
        pss_pkg::RegGainP:     gain_p              <= pwdata[15:0];
        pss_pkg::RegGainI:     gain_i_times_period <= pwdata[15:0];
        pss_pkg::RegGainD:     gain_d_over_period  <= pwdata[15:0];
        pss_pkg::RegDebounce:  debounce_ms         <= pwdata[7:0];
        pss_pkg::RegDutyLimit: duty_limit          <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      pss_pkg::RegGainP:     prdata = {16'd0, gain_p};
      pss_pkg::RegGainI:     prdata = {16'd0, gain_i_times_period};
      pss_pkg::RegGainD:     prdata = {16'd0, gain_d_over_period};
      pss_pkg::RegDebounce:  prdata = {24'd0, debounce_ms};
      pss_pkg::RegDutyLimit: prdata = {24'd0, duty_limit};
      default:               prdata = '0;
    endcase
  end

  // Pipeline flow: a stage loads when empty or when its beat moves on
  assign rdy_out    = !result_valid || !result_stall;
  assign rdy6       = !v6 || rdy_out;
  assign rdy5       = !v5 || rdy6;
  assign rdy4       = !v4 || rdy5;
  assign rdy3       = !v3 || rdy4;
  assign rdy2       = !v2 || rdy3;
  assign rdy1       = !v1 || rdy2;
  assign item_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (rdy1)    v1 <= item_valid;
      if (rdy2)    v2 <= v1;
      if (rdy3)    v3 <= v2;
      if (rdy4)    v4 <= v3;
      if (rdy5)    v5 <= v4;
      if (rdy6)    v6 <= v5;
      if (rdy_out) result_valid <= v6;
    end
  end

  // Entry: angle to whole degrees, fold the upper arc to zero
  always_comb begin
    turn_prod              = 21'(item.raw_angle) * 21'(pss_pkg::DegPerTurn);
    entry_next.mode        = item.mode;
    entry_next.deg_turn    = turn_prod[pss_pkg::EncBits +: 9];
    entry_next.deg_fold    = (entry_next.deg_turn > pss_pkg::FoldAbove) ?
                             9'd0 : entry_next.deg_turn;
    entry_next.press_time_ms = item.press_time_ms;
    entry_next.frame_id    = item.frame_id;
  end

  always_ff @(posedge clk) begin
    if (rdy1) entry <= entry_next;
  end

  // State stage
  pss_state u_state (
    .clk        (clk),
    .rst        (rst),
    .fire       (v1 && rdy2),
    .entry      (entry),
    .debounce_ms(debounce_ms),
    .snap       (snap_st),
    .err        (err_st),
    .prev_err   (perr_st)
  );

  always_ff @(posedge clk) begin
    if (rdy2) begin
      snap2 <= snap_st;
      err2  <= err_st;
      perr2 <= perr_st;
    end
  end

  // Gain products
  always_comb begin
    gp_w  = pss_pkg::ProdW'({1'b0, gain_p});
    gi_w  = pss_pkg::ProdW'({1'b0, gain_i_times_period});
    gd_w  = pss_pkg::ProdW'({1'b0, gain_d_over_period});
    e_w   = {{(pss_pkg::ProdW-8){err2[7]}}, err2};
    ep_w  = {{(pss_pkg::ProdW-10){perr2[9]}}, perr2};
    dif_w = e_w - ep_w;
    sum_w = e_w + ep_w;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      snap3  <= snap2;
      prod_p <= gp_w * e_w;
      prod_d <= gd_w * dif_w;
      prod_i <= gi_w * sum_w;
    end
  end

  // PID sum, sign by direction, times 20, drop the gain fraction
  always_comb begin
    gsum    = pss_pkg::GsumW'(prod_p) + pss_pkg::GsumW'(prod_d) + pss_pkg::GsumW'(prod_i);
    gsum_x  = {{(pss_pkg::SumW-pss_pkg::GsumW){gsum[pss_pkg::GsumW-1]}}, gsum};
    gsum_s  = snap3.e_neg ? -gsum_x : gsum_x;
    gsum_20 = (gsum_s <<< 4) + (gsum_s <<< 2);
    shifted_next = gsum_20[pss_pkg::SumW-1:pss_pkg::GainFracBits];
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      snap4   <= snap3;
      shifted <= shifted_next;
    end
  end

  // Quotient estimate of |sum| / 72 through a reciprocal
  always_comb begin
    neg_next = shifted[pss_pkg::ShW-1];
    mag_next = neg_next ? pss_pkg::ShW'(-shifted) : pss_pkg::ShW'(shifted);
    q_prod   = (pss_pkg::ShW+pss_pkg::RecipW)'(mag_next) *
               (pss_pkg::ShW+pss_pkg::RecipW)'(pss_pkg::Recip72);
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      snap5 <= snap4;
      neg5  <= neg_next;
      mag5  <= mag_next;
      q_est <= q_prod[pss_pkg::RecipK +: pss_pkg::QW];
    end
  end

  // Correct the estimate, then floor toward minus infinity
  always_comb begin
    q_x72 = (pss_pkg::ShW+1)'(q_est) * (pss_pkg::ShW+1)'(pss_pkg::ScaleDen);
    rem   = (pss_pkg::ShW+1)'(mag5) - q_x72;
    if (rem >= (pss_pkg::ShW+1)'(pss_pkg::ScaleDen)) begin
      q_cor = q_est + 1'b1;
      rem1  = rem - (pss_pkg::ShW+1)'(pss_pkg::ScaleDen);
    end else begin
      q_cor = q_est;
      rem1  = rem;
    end
    f_mag     = q_cor + pss_pkg::QW'(neg5 && (rem1 != '0));
    step_next = neg5 ? -$signed({1'b0, f_mag}) : $signed({1'b0, f_mag});
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      snap6 <= snap5;
      step6 <= step_next;
    end
  end

  // Output stage: on a tick, add the step to the active duty, clamp to [0, limit]
  always_comb begin
    prev_duty = snap6.e_neg ? duty_a : duty_b;
    duty_sum  = $signed(pss_pkg::SatW'(prev_duty)) +
                {{(pss_pkg::SatW-pss_pkg::FW){step6[pss_pkg::FW-1]}}, step6};
    if (duty_sum[pss_pkg::SatW-1]) begin
      duty_new = 8'd0;
    end else if (duty_sum > $signed(pss_pkg::SatW'(duty_limit))) begin
      duty_new = duty_limit;
    end else begin
      duty_new = duty_sum[7:0];
    end

    result_next.drive_a       = duty_a;
    result_next.drive_b       = duty_b;
    if (snap6.tick) begin
      result_next.drive_a = snap6.e_neg ? duty_new : 8'd0;
      result_next.drive_b = snap6.e_neg ? 8'd0 : duty_new;
    end
    result_next.angle_degrees = snap6.angle;
    result_next.setpoint      = snap6.setpoint;
    result_next.reply_valid   = snap6.reply;
    result_next.reply_byte    = snap6.reply ? snap6.angle[7:0] : 8'd0;
    result_next.pose_index    = snap6.pose;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_a <= '0;
      duty_b <= '0;
    end else if (v6 && rdy_out) begin
      duty_a <= result_next.drive_a;
      duty_b <= result_next.drive_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) result <= result_next;
  end

endmodule

`default_nettype wire

// File: src/pss_state.sv
// ----------------------------------------------------------------------------
// pss_state: servo state registers and command handling
// Holds the reference, previous error, press time and held angle, forms the
// scaled error of a tick and applies buttons, bus frames and start seeding.
// ----------------------------------------------------------------------------
`default_nettype none

module pss_state (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            fire,
  input  wire pss_pkg::entry_t entry,
  input  wire logic [7:0]      debounce_ms,
  output pss_pkg::snap_t       snap,
  output logic signed [7:0]    err,
  output logic signed [9:0]    prev_err
);

  logic [8:0]         reference_deg, reference_deg_next;
  logic signed [9:0]  previous_error, previous_error_next;
  logic [31:0]        last_press_ms, last_press_ms_next;
  logic [8:0]         held_angle_deg, held_angle_deg_next;

  logic signed [9:0]  diff;
  logic [8:0]         diff_mag;
  logic [10:0]        diff_x5;
  logic [22:0]        err_prod;
  logic [6:0]         err_mag;
  logic [31:0]        elapsed;
  logic               reply;
  logic [1:0]         pose;

  // Scaled error: trunc((ref - deg) * 20 / 72) through a Q16 reciprocal
  always_comb begin
    diff     = $signed({1'b0, reference_deg}) - $signed({1'b0, entry.deg_fold});
    diff_mag = diff[9] ? 9'(-diff) : diff[8:0];
    diff_x5  = 11'({diff_mag, 2'b00}) + 11'(diff_mag);
    err_prod = 23'(diff_x5) * 23'(pss_pkg::ErrRecip);
    err_mag  = err_prod[pss_pkg::ErrRecipSh +: 7];
    err      = diff[9] ? -$signed({1'b0, err_mag}) : $signed({1'b0, err_mag});
  end

  assign elapsed = entry.press_time_ms - last_press_ms;

  // Next state per command
  always_comb begin
    reference_deg_next  = reference_deg;
    previous_error_next = previous_error;
    last_press_ms_next  = last_press_ms;
    held_angle_deg_next = held_angle_deg;
    reply               = 1'b0;
    case (entry.mode)
      pss_pkg::ModeTick: begin
        held_angle_deg_next = entry.deg_fold;
        previous_error_next = {{2{err[7]}}, err};
      end
      pss_pkg::ModeUp, pss_pkg::ModeDown: begin
        if (elapsed > {24'd0, debounce_ms}) begin
          if (entry.mode == pss_pkg::ModeUp) begin
            reference_deg_next = (reference_deg >= pss_pkg::UpThresh) ?
                                 pss_pkg::UpTop : reference_deg + pss_pkg::RefStep;
          end else begin
            reference_deg_next = (reference_deg <= pss_pkg::DownThresh) ?
                                 pss_pkg::DownBottom : reference_deg - pss_pkg::RefStep;
          end
        end
        last_press_ms_next = entry.press_time_ms;
      end
      pss_pkg::ModeFrame: begin
        case (entry.frame_id)
          pss_pkg::FidPresetHigh: reference_deg_next = pss_pkg::RefHigh;
          pss_pkg::FidPresetMid:  reference_deg_next = pss_pkg::RefMid;
          pss_pkg::FidPresetLow:  reference_deg_next = pss_pkg::RefLow;
          pss_pkg::FidPosRequest: reply = 1'b1;
          default: ;
        endcase
      end
      pss_pkg::ModeStart: begin
        reference_deg_next  = entry.deg_turn;
        previous_error_next = $signed({1'b0, entry.deg_turn});
      end
      default: ;
    endcase
  end

  // Pose bucket of the new reference
  always_comb begin
    if (reference_deg_next >= pss_pkg::PoseLo && reference_deg_next < pss_pkg::PoseMid) begin
      pose = pss_pkg::PoseNear;
    end else if (reference_deg_next >= pss_pkg::PoseMid &&
                 reference_deg_next < pss_pkg::PoseHi) begin
      pose = pss_pkg::PoseCentr;
    end else begin
      pose = pss_pkg::PoseOther;
    end
  end

  always_comb begin
    snap.tick     = (entry.mode == pss_pkg::ModeTick);
    snap.e_neg    = err[7];
    snap.angle    = held_angle_deg_next;
    snap.setpoint = reference_deg_next;
    snap.reply    = reply;
    snap.pose     = pose;
  end

  assign prev_err = previous_error;

  // Commit the state as the item leaves the entry stage
  always_ff @(posedge clk) begin
    if (rst) begin
      reference_deg  <= '0;
      previous_error <= '0;
      last_press_ms  <= '0;
      held_angle_deg <= '0;
    end else if (fire) begin
      reference_deg  <= reference_deg_next;
      previous_error <= previous_error_next;
      last_press_ms  <= last_press_ms_next;
      held_angle_deg <= held_angle_deg_next;
    end
  end

endmodule

`default_nettype wire

// File: verif/pid_position_servo_with_setpoint_core_tb.sv
// ----------------------------------------------------------------------------
// pid_position_servo_with_setpoint_core_tb: self-checking bench of the servo core
// Drives control ticks, button presses, bus frames, start and spare-mode items
// through the valid/stall item channel. Each accepted beat is run through a local
// servo predictor and the result beats are compared field by field. The
// register set is reprogrammed over APB between phases, including the
// extremes, and the item channel idles and the result channel stalls at random in several mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_position_servo_with_setpoint_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pss_pkg::*;

  // Modes the core reports without acting on them
  localparam logic [2:0] ModeSpare5 = 3'd5;
  localparam logic [2:0] ModeSpare6 = 3'd6;
  localparam logic [2:0] ModeSpare7 = 3'd7;

  localparam int CycleLimit  = 400000;
  localparam int SettleTicks = 30;

  // Clock, reset and block ports
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_stall;
  item_t       item         = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  result_t     result;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [4:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  pid_position_servo_with_setpoint_core u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #2 clk = ~clk;

  // Register copies used by the predictor
  int cfg_gain_p    = GainPReset;
  int cfg_gain_i    = GainIReset;
  int cfg_gain_d    = GainDReset;
  int cfg_debounce  = DebounceReset;
  int cfg_duty_lim  = DutyLimitReset;

  // Servo state copies
  int          ref_deg    = 0;
  int          prev_err   = 0;
  int          duty_a     = 0;
  int          duty_b     = 0;
  logic [31:0] last_press = '0;
  int          held_deg   = 0;

  // Bench bookkeeping
  item_t   command_queue[$];
  result_t due_results[$];
  result_t want;
  bit      item_taken   = 1'b0;
  int      idle_pct     = 0;
  int      stall_pct    = 0;
  int      failures     = 0;
  int      results_seen = 0;
  int      settings     = 1;
  int      cycle_count  = 0;
  int      mode_seen[8];

  // Stimulus-side guesses of the reference and the press clock
  int          aim_deg   = 0;
  logic [31:0] gen_press = '0;

  // Clamp a duty numerator over 72 * 2^F into [0, duty_limit]
  function automatic int clamp_duty(longint num);
    longint q;
    q = num / (longint'(ScaleDen) << GainFracBits);
    if (q < 0) q = 0;
    if (q > cfg_duty_lim) q = cfg_duty_lim;
    return int'(q);
  endfunction

  // Apply one command to the servo state and form its result beat
  function automatic result_t servo_predict(item_t it);
    result_t     r;
    int          deg;
    int          err;
    longint      gsum;
    longint      den;
    logic [31:0] gap;
    logic        reply;
    reply = 1'b0;
    den   = longint'(ScaleDen) << GainFracBits;
    case (it.mode)
      ModeTick: begin
        deg = int'({20'd0, it.raw_angle}) * DegPerTurn / (1 << EncBits);
        if (deg > FoldAbove) deg = 0;
        held_deg = deg;
        err  = ((ref_deg - deg) * ScaleNum) / ScaleDen;
        gsum = longint'(cfg_gain_p) * err
             + longint'(cfg_gain_d) * (err - prev_err)
             + longint'(cfg_gain_i) * (err + prev_err);
        if (err < 0) begin
          duty_a = clamp_duty(-gsum * ScaleNum + longint'(duty_a) * den);
          duty_b = 0;
        end else begin
          duty_b = clamp_duty(gsum * ScaleNum + longint'(duty_b) * den);
          duty_a = 0;
        end
        prev_err = err;
      end
      ModeUp, ModeDown: begin
        gap = it.press_time_ms - last_press;
        if (gap > cfg_debounce) begin
          if (it.mode == ModeUp)
            ref_deg = (ref_deg >= UpThresh) ? UpTop : ref_deg + RefStep;
          else
            ref_deg = (ref_deg <= DownThresh) ? DownBottom : ref_deg - RefStep;
        end
        last_press = it.press_time_ms;
      end
      ModeFrame: begin
        case (it.frame_id)
          FidPresetHigh: ref_deg = RefHigh;
          FidPresetMid:  ref_deg = RefMid;
          FidPresetLow:  ref_deg = RefLow;
          FidPosRequest: reply = 1'b1;
          default: ;
        endcase
      end
      ModeStart: begin
        ref_deg  = int'({20'd0, it.raw_angle}) * DegPerTurn / (1 << EncBits);
        prev_err = ref_deg;
      end
      default: ;
    endcase
    r.drive_a       = duty_a[7:0];
    r.drive_b       = duty_b[7:0];
    r.angle_degrees = held_deg[8:0];
    r.setpoint      = ref_deg[8:0];
    r.reply_valid   = reply;
    r.reply_byte    = reply ? held_deg[7:0] : 8'd0;
    if (ref_deg >= PoseLo && ref_deg < PoseMid) r.pose_index = PoseNear;
    else if (ref_deg >= PoseMid && ref_deg < PoseHi) r.pose_index = PoseCentr;
    else r.pose_index = PoseOther;
    return r;
  endfunction

  task automatic check_field(string name, int exp_val, int got_val);
    if (exp_val != got_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
      failures++;
    end
  endtask

  // Accept item beats and predict; compare result beats in order
  always @(posedge clk) begin
    if (rst) begin
      item_taken = 1'b0;
    end else begin
      item_taken = item_valid && !item_stall;
      if (item_taken) begin
        due_results.push_back(servo_predict(item));
        mode_seen[item.mode]++;
      end
      if (result_valid && !result_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time, result);
          failures++;
        end else begin
          want = due_results.pop_front();
          results_seen++;
          check_field("drive_a", want.drive_a, result.drive_a);
          check_field("drive_b", want.drive_b, result.drive_b);
          check_field("angle_degrees", want.angle_degrees, result.angle_degrees);
          check_field("setpoint", want.setpoint, result.setpoint);
          check_field("reply_valid", want.reply_valid, result.reply_valid);
          check_field("reply_byte", want.reply_byte, result.reply_byte);
          check_field("pose_index", want.pose_index, result.pose_index);
        end
      end
    end
  end

  // Feed item beats from the queue and drive a random result stall; hold a beat until it is taken
  always @(negedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      result_stall <= 1'b0;
    end else begin
      result_stall <= ($urandom_range(0, 99) < stall_pct);
      if (!item_valid || item_taken) begin
        if (command_queue.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          item       <= command_queue.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: run exceeded %0d cycles", $time, CycleLimit);
      $display("FAIL pid_position_servo_with_setpoint_core");
      $finish;
    end
  end

  // Write one register, read it back, and update the predictor's copy
  task automatic program_reg(logic [2:0] idx, logic [31:0] val);
    logic [31:0] mask;
    mask = (idx == RegDebounce || idx == RegDutyLimit) ? 32'hFF : 32'hFFFF;
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if ((prdata & mask) != (val & mask)) begin
      $display("%0t: register %0d readback, expected %0d, got %0d",
               $time, idx, val & mask, prdata & mask);
      failures++;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
    case (idx)
      RegGainP:     cfg_gain_p   = int'(val & mask);
      RegGainI:     cfg_gain_i   = int'(val & mask);
      RegGainD:     cfg_gain_d   = int'(val & mask);
      RegDebounce:  cfg_debounce = int'(val & mask);
      RegDutyLimit: cfg_duty_lim = int'(val & mask);
      default: ;
    endcase
  endtask

  task automatic apply_settings(int gp, int gi, int gd, int db, int lim);
    program_reg(RegGainP, gp);
    program_reg(RegGainI, gi);
    program_reg(RegGainD, gd);
    program_reg(RegDebounce, db);
    program_reg(RegDutyLimit, lim);
    settings++;
  endtask

  // Hold until every queued beat is taken and every result is back
  task automatic drain();
    @(negedge clk);
    while (command_queue.size() != 0 || item_valid || due_results.size() != 0)
      @(negedge clk);
  endtask

  // Item with random content in every field but the mode
  function automatic item_t noisy_item(logic [2:0] mode);
    item_t it;
    it.mode          = mode;
    it.raw_angle     = 12'($urandom());
    it.press_time_ms = $urandom();
    it.frame_id      = 11'($urandom());
    return it;
  endfunction

  task automatic push(logic [2:0] mode, int raw, logic [31:0] press, int fid);
    item_t it;
    it.mode          = mode;
    it.raw_angle     = 12'(raw);
    it.press_time_ms = press;
    it.frame_id      = 11'(fid);
    command_queue.push_back(it);
  endtask

  // Mostly ticks, half of them near the reference, with presses, frames, starts and noise
  task automatic push_random(int count);
    item_t it;
    int    pick;
    int    deg;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 58) begin
        it = noisy_item(ModeTick);
        if ($urandom_range(0, 1) == 0) begin
          deg = aim_deg + $urandom_range(0, 40) - 20;
          if (deg < 0) deg = 0;
          if (deg > 359) deg = 359;
          it.raw_angle = 12'((deg * 4096 + 359) / 360 + $urandom_range(0, 10));
        end
      end else if (pick < 70) begin
        it = noisy_item($urandom_range(0, 1) ? ModeUp : ModeDown);
        if ($urandom_range(0, 4) == 0) gen_press = $urandom();
        else gen_press = gen_press + $urandom_range(0, 2 * cfg_debounce + 4);
        it.press_time_ms = gen_press;
      end else if (pick < 84) begin
        it = noisy_item(ModeFrame);
        case ($urandom_range(0, 4))
          0: begin it.frame_id = FidPresetHigh; aim_deg = RefHigh; end
          1: begin it.frame_id = FidPresetMid;  aim_deg = RefMid;  end
          2: begin it.frame_id = FidPresetLow;  aim_deg = RefLow;  end
          3: it.frame_id = FidPosRequest;
          default: ;
        endcase
      end else if (pick < 94) begin
        it = noisy_item(ModeStart);
        aim_deg = int'({20'd0, it.raw_angle}) * 360 / 4096;
      end else begin
        it = noisy_item(3'($urandom_range(ModeSpare5, ModeSpare7)));
      end
      command_queue.push_back(it);
    end
  endtask

  task automatic run_phase(int idle_mix, int stall_mix, int count);
    idle_pct  = idle_mix;
    stall_pct = stall_mix;
    push_random(count);
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes, fold boundary, every command, debounce edges
    push(ModeTick, 0, 32'hFFFF_FFFF, 11'h7FF);
    push(ModeStart, 4095, 32'h0, 11'h0);
    push(ModeTick, 4095, 32'h0, 11'h0);
    push(ModeTick, 3414, 32'h0, 11'h0);
    push(ModeTick, 3425, 32'h0, 11'h0);
    push(ModeFrame, 0, 32'h0, FidPresetHigh);
    push(ModeTick, 2048, 32'h0, 11'h0);
    push(ModeUp, 0, 32'd10, 11'h0);
    push(ModeUp, 0, 32'd61, 11'h0);
    push(ModeUp, 0, 32'd200, 11'h0);
    push(ModeFrame, 0, 32'h0, FidPresetLow);
    push(ModeDown, 0, 32'd300, 11'h0);
    push(ModeFrame, 0, 32'h0, FidPresetMid);
    push(ModeDown, 0, 32'd360, 11'h0);
    push(ModeUp, 0, 32'd410, 11'h0);
    push(ModeFrame, 0, 32'h0, FidPosRequest);
    push(ModeFrame, 4095, 32'hFFFF_FFFF, 11'h7FF);
    push(ModeSpare5, 4095, 32'hFFFF_FFFF, 11'h7FF);
    push(ModeSpare6, 0, 32'h0, FidPosRequest);
    push(ModeSpare7, 1234, 32'h5555_AAAA, FidPresetHigh);
    push(ModeUp, 0, 32'hFFFF_FFF0, 11'h0);
    push(ModeDown, 0, 32'h0000_0020, 11'h0);
    push(ModeStart, 0, 32'h0, 11'h0);
    push(ModeTick, 1024, 32'h0, 11'h0);
    push(ModeTick, 0, 32'h0, 11'h0);
    drain();
    gen_press = 32'h0000_0020;

    // Random phases over several register settings and idle and stall mixes
    run_phase(0, 0, 85);
    apply_settings(65535, 65535, 65535, 0, 255);
    run_phase(65, 0, 85);
    apply_settings(0, 0, 0, 255, 0);
    run_phase(0, 65, 85);
    apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 255), 255);
    run_phase(10, 10, 85);
    apply_settings(40000, 5000, 20000, 50, 128);
    run_phase(0, 0, 85);
    apply_settings($urandom_range(0, 65535), $urandom_range(0, 8000),
                   $urandom_range(0, 30000), $urandom_range(0, 255),
                   $urandom_range(0, 255));
    run_phase(65, 65, 85);

    // Let any stray beat show up before the verdict
    idle_pct  = 0;
    stall_pct = 0;
    repeat (SettleTicks) @(posedge clk);
    if (due_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, due_results.size());
      failures++;
    end

    $display("Covered %0d ticks, %0d presses, %0d frames, %0d starts, %0d spare-mode items",
             mode_seen[ModeTick], mode_seen[ModeUp] + mode_seen[ModeDown],
             mode_seen[ModeFrame], mode_seen[ModeStart],
             mode_seen[ModeSpare5] + mode_seen[ModeSpare6] + mode_seen[ModeSpare7]);
    $display("Checked %0d results over %0d register settings, %0d failures",
             results_seen, settings, failures);
    if (failures == 0) begin
      $display("PASS pid_position_servo_with_setpoint_core");
    end else begin
      $display("FAIL pid_position_servo_with_setpoint_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
